[design/tpa_pkg.sv]
`timescale 1ns / 1ps
// Package for the two-class priority admission block.
// Holds payload structs, event codes and controller/datapath interface structs.
package tpa_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W            = 8;
    localparam int OCC_W           = 8;
    localparam logic [OCC_W-1:0] CAPACITY_RESET = 8'd5;

    // Request type codes
    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_LEAVE  = 1'b1;

    typedef enum logic [1:0] {
        EV_ADMIT       = 2'd0,
        EV_FULL        = 2'd1,
        EV_EMPTY_LEAVE = 2'd2
    } ev_kind_t;

    typedef struct packed {
        logic            req_type;
        logic            is_vip;
        logic [ID_W-1:0] client_id;
    } req_t;

    typedef struct packed {
        ev_kind_t         event_kind;
        logic [ID_W-1:0]  out_client_id;
        logic             out_vip;
        logic [OCC_W-1:0] occupancy_now;
    } evt_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch incoming request
        logic apply;     // push arrival or retire a leave
        logic early;     // stage a rejection or empty-leave event
        logic pop;       // admit a queue head, issue the memory read
        logic pop_vip;   // class popped
        logic take_id;   // stage the admit event from read data
        logic load;      // move staged event into output register
    } tpa_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_leave;
        logic is_vip;
        logic occ_zero;
        logic vip_full;
        logic norm_full;
        logic below_cap;
        logic vip_any;
        logic norm_any;
        logic out_free;
    } tpa_stat_t;

endpackage

[design/two_class_priority_admission.sv]
`timescale 1ns / 1ps
// Two-class priority admission controller: arrivals queue by class, leaves free
// a slot, and at most one client is admitted per request, VIP heads first, while
// occupancy is below the capacity register. One request is handled at a time:
// an arrival or leave that admits nobody passes the capture, execute and admit
// states, a queue-full or empty-leave event the capture, execute and load states,
// and an admission also a read state for the registered read of the queue memory
// before load. The finished event waits in an output register, so the next
// request is accepted while it is stalled. Queue memories need no clearing pass.
// Depends on tpa_pkg, tpa_ctrl, tpa_dpath and tpa_ram.
module two_class_priority_admission
    import tpa_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req,
    output logic             evt_valid,
    input  logic             evt_stall,
    output evt_t             evt,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [OCC_W-1:0] cfg_data
);

    tpa_cmd_t  cmd;
    tpa_stat_t stat;

    // Capacity writes are always taken
    assign cfg_ready = 1'b1;

    tpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tpa_dpath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .evt_stall (evt_stall),
        .evt_valid (evt_valid),
        .evt       (evt),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[design/tpa_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module tpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/tpa_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine for the admission block.
// Depends on tpa_pkg for the command and status structs.
module tpa_ctrl
    import tpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  tpa_stat_t stat,
    output tpa_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADMIT,
        S_READ,
        S_LOAD
    } st_t;

    st_t state_reg, state_next;
    logic reject;

    // Arrival into a full queue or leave from an empty room ends the step early
    assign reject = stat.is_leave ? stat.occ_zero
                                  : (stat.is_vip ? stat.vip_full : stat.norm_full);

    assign req_stall = (state_reg != S_IDLE);

    // Decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (reject)
                begin
                    cmd.early  = 1'b1;
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_ADMIT;
                end
            end
            S_ADMIT:
            begin
                if (stat.below_cap && (stat.vip_any || stat.norm_any))
                begin
                    cmd.pop     = 1'b1;
                    cmd.pop_vip = stat.vip_any;
                    state_next  = S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.take_id = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_read_after_admit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> ($past(state_reg) == S_ADMIT))
        else $error("read stage entered without an admission");

    a_no_pop_over_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> stat.below_cap)
        else $error("admission issued at or above capacity");

    a_capture_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> ($past(state_reg) == S_IDLE && $past(req_valid)))
        else $error("execute stage without a captured request");

endmodule

[design/tpa_dpath.sv]
`timescale 1ns / 1ps
// Datapath for the admission block: class queues, counters, occupancy, capacity
// and the output register. Depends on tpa_pkg and tpa_ram.
module tpa_dpath
    import tpa_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  req_t             req,
    input  logic             cfg_valid,
    input  logic [OCC_W-1:0] cfg_data,
    input  logic             evt_stall,
    output logic             evt_valid,
    output evt_t             evt,
    input  tpa_cmd_t         cmd,
    output tpa_stat_t        stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

    req_t             item_reg;
    logic [PTR_W-1:0] vip_head_reg,   vip_head_next;
    logic [CNT_W-1:0] vip_count_reg,  vip_count_next;
    logic [PTR_W-1:0] norm_head_reg,  norm_head_next;
    logic [CNT_W-1:0] norm_count_reg, norm_count_next;
    logic [OCC_W-1:0] occ_reg,        occ_next;
    logic [OCC_W-1:0] cap_reg;
    ev_kind_t         res_kind_reg;
    logic [ID_W-1:0]  res_id_reg;
    logic             res_vip_reg;
    logic             pop_vip_reg;
    logic             evt_valid_reg;
    evt_t             evt_reg;

    logic [SUM_W-1:0] vip_sum, norm_sum;
    logic [PTR_W-1:0] vip_waddr, norm_waddr;
    logic             vip_we, norm_we, vip_re, norm_re;
    logic [ID_W-1:0]  vip_rdata, norm_rdata;
    logic             push_vip, push_norm, pop_v, pop_n;

    // Write position is head plus count, wrapped once
    assign vip_sum    = SUM_W'(vip_head_reg) + SUM_W'(vip_count_reg);
    assign norm_sum   = SUM_W'(norm_head_reg) + SUM_W'(norm_count_reg);
    assign vip_waddr  = PTR_W'((vip_sum >= DEPTH_S) ? (vip_sum - DEPTH_S) : vip_sum);
    assign norm_waddr = PTR_W'((norm_sum >= DEPTH_S) ? (norm_sum - DEPTH_S) : norm_sum);

    assign push_vip  = cmd.apply && (item_reg.req_type == REQ_ARRIVE) && item_reg.is_vip;
    assign push_norm = cmd.apply && (item_reg.req_type == REQ_ARRIVE) && !item_reg.is_vip;
    assign pop_v     = cmd.pop && cmd.pop_vip;
    assign pop_n     = cmd.pop && !cmd.pop_vip;

    assign vip_we  = push_vip;
    assign norm_we = push_norm;
    assign vip_re  = pop_v;
    assign norm_re = pop_n;

    tpa_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_vip_ram (
        .clk   (clk),
        .we    (vip_we),
        .waddr (vip_waddr),
        .wdata (item_reg.client_id),
        .re    (vip_re),
        .raddr (vip_head_reg),
        .rdata (vip_rdata)
    );

    tpa_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_norm_ram (
        .clk   (clk),
        .we    (norm_we),
        .waddr (norm_waddr),
        .wdata (item_reg.client_id),
        .re    (norm_re),
        .raddr (norm_head_reg),
        .rdata (norm_rdata)
    );

    // Status toward the controller
    always_comb
    begin
        stat.is_leave  = (item_reg.req_type == REQ_LEAVE);
        stat.is_vip    = item_reg.is_vip;
        stat.occ_zero  = (occ_reg == '0);
        stat.vip_full  = (vip_count_reg >= DEPTH_C);
        stat.norm_full = (norm_count_reg >= DEPTH_C);
        stat.below_cap = (occ_reg < cap_reg);
        stat.vip_any   = (vip_count_reg != '0);
        stat.norm_any  = (norm_count_reg != '0);
        stat.out_free  = !evt_valid_reg || !evt_stall;
    end

    // Advance counters, heads and occupancy
    always_comb
    begin
        vip_head_next   = vip_head_reg;
        vip_count_next  = vip_count_reg;
        norm_head_next  = norm_head_reg;
        norm_count_next = norm_count_reg;
        occ_next        = occ_reg;
        if (cmd.apply && (item_reg.req_type == REQ_LEAVE))
        begin
            occ_next = occ_reg - 1'b1;
        end
        if (push_vip)
        begin
            vip_count_next = vip_count_reg + 1'b1;
        end
        if (push_norm)
        begin
            norm_count_next = norm_count_reg + 1'b1;
        end
        if (pop_v)
        begin
            vip_head_next  = (vip_head_reg == LAST_P) ? '0 : vip_head_reg + 1'b1;
            vip_count_next = vip_count_reg - 1'b1;
            occ_next       = occ_reg + 1'b1;
        end
        if (pop_n)
        begin
            norm_head_next  = (norm_head_reg == LAST_P) ? '0 : norm_head_reg + 1'b1;
            norm_count_next = norm_count_reg - 1'b1;
            occ_next        = occ_reg + 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vip_head_reg   <= '0;
            vip_count_reg  <= '0;
            norm_head_reg  <= '0;
            norm_count_reg <= '0;
            occ_reg        <= '0;
            cap_reg        <= CAPACITY_RESET;
            evt_valid_reg  <= 1'b0;
        end
        else
        begin
            vip_head_reg   <= vip_head_next;
            vip_count_reg  <= vip_count_next;
            norm_head_reg  <= norm_head_next;
            norm_count_reg <= norm_count_next;
            occ_reg        <= occ_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                evt_valid_reg <= 1'b1;
            end
            else if (!evt_stall)
            begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: captured request, staged event, output event
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
        if (cmd.pop)
        begin
            pop_vip_reg <= cmd.pop_vip;
        end
        if (cmd.early)
        begin
            if (item_reg.req_type == REQ_LEAVE)
            begin
                res_kind_reg <= EV_EMPTY_LEAVE;
                res_id_reg   <= '0;
                res_vip_reg  <= 1'b0;
            end
            else
            begin
                res_kind_reg <= EV_FULL;
                res_id_reg   <= item_reg.client_id;
                res_vip_reg  <= item_reg.is_vip;
            end
        end
        else if (cmd.take_id)
        begin
            res_kind_reg <= EV_ADMIT;
            res_id_reg   <= pop_vip_reg ? vip_rdata : norm_rdata;
            res_vip_reg  <= pop_vip_reg;
        end
        if (cmd.load)
        begin
            evt_reg.event_kind    <= res_kind_reg;
            evt_reg.out_client_id <= res_id_reg;
            evt_reg.out_vip       <= res_vip_reg;
            evt_reg.occupancy_now <= occ_reg;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vip_count_reg <= DEPTH_C) && (norm_count_reg <= DEPTH_C))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (cmd.pop_vip ? (vip_count_reg != '0)
                                 : (norm_count_reg != '0 && vip_count_reg == '0)))
        else $error("pop from empty queue or normal served over waiting vip");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!evt_valid_reg || !evt_stall))
        else $error("output event overwritten while stalled");

endmodule
